FILE: hdl/cbc_pkg.sv
// shared types, codes and helpers for the cartridge bank controller
package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int OP_W       = 2;
    localparam int TGT_W      = 2;
    localparam int MADDR_W    = 23;
    localparam int CTYPE_W    = 3;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int CLK_SEL_W  = 4;
    localparam int CLK_IDX_W  = 3;
    localparam int CLK_REGS   = 5;

    localparam int ROM_BANK_BITS_DEF = 9;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [TGT_W-1:0]   t_target;
    typedef logic [CTYPE_W-1:0] t_ctype;

    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    localparam t_target TGT_NONE  = 2'd0;
    localparam t_target TGT_ROM   = 2'd1;
    localparam t_target TGT_RAM   = 2'd2;
    localparam t_target TGT_CLOCK = 2'd3;

    localparam t_ctype CT_NONE = 3'd0;
    localparam t_ctype CT_MBC1 = 3'd1;
    localparam t_ctype CT_MBC2 = 3'd2;
    localparam t_ctype CT_MBC3 = 3'd3;
    localparam t_ctype CT_MBC5 = 3'd4;

    // clock register indexes and day high byte bits
    localparam logic [CLK_IDX_W-1:0] CLK_SEC     = 3'd0;
    localparam logic [CLK_IDX_W-1:0] CLK_MIN     = 3'd1;
    localparam logic [CLK_IDX_W-1:0] CLK_HOUR    = 3'd2;
    localparam logic [CLK_IDX_W-1:0] CLK_DAY_LO  = 3'd3;
    localparam logic [CLK_IDX_W-1:0] CLK_DAY_HI  = 3'd4;
    localparam int                   DAY_MSB_BIT = 0;
    localparam int                   HALT_BIT    = 6;
    localparam int                   CARRY_BIT   = 7;
    localparam logic [DATA_W-1:0]    SEC_LIMIT   = 8'd60;
    localparam logic [DATA_W-1:0]    HOUR_LIMIT  = 8'd24;

    typedef struct packed {
        logic                  tick;
        logic                  wr;
        logic                  latch;
        logic [CLK_IDX_W-1:0]  idx;
        logic [DATA_W-1:0]     data;
    } t_rtc_ctrl;

    // mbc1 cannot select banks 0x00/0x20/0x40/0x60, it bumps to the next one
    function automatic logic [ROM_BANK_W-1:0] mbc1_fix(input logic [ROM_BANK_W-1:0] b);
        logic [ROM_BANK_W-1:0] r;
        r = b;
        if (b == 9'h000 || b == 9'h020 || b == 9'h040 || b == 9'h060) begin
            r = b + 9'd1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/cbc_if.sv
// valid/ready channel interfaces for the bank controller
interface cbc_in_if import cbc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    modport source (output valid, op, address, data, input ready);
    modport sink   (input valid, op, address, data, output ready);
endinterface

interface cbc_out_if import cbc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TGT_W-1:0]   target;
    logic               is_write;
    logic [MADDR_W-1:0] mem_address;
    logic [DATA_W-1:0]  clock_value;
    modport source (output valid, target, is_write, mem_address, clock_value, input ready);
    modport sink   (input valid, target, is_write, mem_address, clock_value, output ready);
endinterface

interface cbc_cfg_if import cbc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CTYPE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/cbc_rtc.sv
// real-time clock registers: live and latched copies, tick, write, latch
module cbc_rtc import cbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rtc_ctrl         i_ctrl,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_live    [CLK_REGS];
    logic [DATA_W-1:0] r_latched [CLK_REGS];
    logic [DATA_W-1:0] n_live    [CLK_REGS];
    logic [DATA_W-1:0] n_latched [CLK_REGS];

    logic [DATA_W-1:0] sec_inc;
    logic [DATA_W-1:0] min_inc;
    logic [DATA_W-1:0] hour_inc;
    logic [9:0]        day_inc;
    logic              idx_ok;

    assign idx_ok   = i_ctrl.idx < CLK_IDX_W'(CLK_REGS);
    assign sec_inc  = r_live[CLK_SEC] + 8'd1;
    assign min_inc  = r_live[CLK_MIN] + 8'd1;
    assign hour_inc = r_live[CLK_HOUR] + 8'd1;
    assign day_inc  = {1'b0, r_live[CLK_DAY_HI][DAY_MSB_BIT], r_live[CLK_DAY_LO]} + 10'd1;

    always_comb begin
        n_live    = r_live;
        n_latched = r_latched;
        if (i_ctrl.tick && !r_live[CLK_DAY_HI][HALT_BIT]) begin
            if (sec_inc < SEC_LIMIT) begin
                n_live[CLK_SEC] = sec_inc;
            end else begin
                n_live[CLK_SEC] = '0;
                if (min_inc < SEC_LIMIT) begin
                    n_live[CLK_MIN] = min_inc;
                end else begin
                    n_live[CLK_MIN] = '0;
                    if (hour_inc < HOUR_LIMIT) begin
                        n_live[CLK_HOUR] = hour_inc;
                    end else begin
                        n_live[CLK_HOUR] = '0;
                        // 9-bit day counter wraps to zero and sets carry
                        if (day_inc[9]) begin
                            n_live[CLK_DAY_LO] = '0;
                            n_live[CLK_DAY_HI][DAY_MSB_BIT] = 1'b0;
                            n_live[CLK_DAY_HI][CARRY_BIT]   = 1'b1;
                        end else begin
                            n_live[CLK_DAY_LO] = day_inc[7:0];
                            n_live[CLK_DAY_HI][DAY_MSB_BIT] = day_inc[8];
                        end
                    end
                end
            end
        end
        if (i_ctrl.wr && idx_ok) begin
            n_live[i_ctrl.idx]    = i_ctrl.data;
            n_latched[i_ctrl.idx] = i_ctrl.data;
        end
        if (i_ctrl.latch) begin
            n_latched = r_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLK_REGS; k++) begin
                r_live[k]    <= '0;
                r_latched[k] <= '0;
            end
        end else begin
            r_live    <= n_live;
            r_latched <= n_latched;
        end
    end

    assign o_rd_data = idx_ok ? r_latched[i_ctrl.idx] : '0;

endmodule

FILE: hdl/cartridge_bank_controller_rtc_top.sv
// Cartridge bank controller (MBC1/MBC2/MBC3 with clock/MBC5). One transaction per clock
// cycle is taken on i_in: a bus read, a bus write or a one-second tick, and each gives exactly
// one result on o_out through the input register and then the result register, so the
// sustained rate is one transaction per cycle whenever o_out is ready; all bank and clock
// state is updated by combinational logic between those two registers. Command writes below
// 0x8000 change banks, mode, clock select or the clock latch and give target none. The clock
// window (MBC3 only, register 0x08-0x0C selected) reads the latched copy; writes set both
// copies. The controller type is written over i_cfg, which is always ready; write it only
// while no transaction is in flight.
module cartridge_bank_controller_rtc_top import cbc_pkg::*; #(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbc_in_if.sink      i_in,
    cbc_out_if.source   o_out,
    cbc_cfg_if.sink     i_cfg
);

    // address regions, upper three address bits
    localparam logic [2:0] RGN_ROM_SEL  = 3'b001;
    localparam logic [2:0] RGN_UPPER    = 3'b010;
    localparam logic [2:0] RGN_MODE     = 3'b011;
    localparam logic [2:0] RGN_EXT_RAM  = 3'b101;
    // mbc5 splits the rom select region by address bit 12
    localparam logic [3:0] RGN5_ROM_LO  = 4'h2;
    localparam logic [3:0] RGN5_ROM_HI  = 4'h3;
    localparam logic [ROM_BANK_W-1:0] BANK_MASK =
        ROM_BANK_W'((1 << ROM_BANK_BITS) - 1);

    // control state
    logic                  r_in_valid;
    logic                  r_out_valid;
    t_ctype                r_ctype;
    logic [ROM_BANK_W-1:0] r_rom_bank,   n_rom_bank;
    logic [RAM_BANK_W-1:0] r_ram_bank,   n_ram_bank;
    logic                  r_mode,       n_mode;
    logic [DATA_W-1:0]     r_rom_lo,     n_rom_lo;
    logic                  r_rom_hi,     n_rom_hi;
    logic                  r_clk_en,     n_clk_en;
    logic [CLK_SEL_W-1:0]  r_clk_sel,    n_clk_sel;
    logic                  r_latch_prev, n_latch_prev;

    // input register payload
    t_op                   r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [DATA_W-1:0]     r_data;

    // result register payload
    t_target               r_target,   n_target;
    logic                  r_is_write, n_is_write;
    logic [MADDR_W-1:0]    r_maddr,    n_maddr;
    logic [DATA_W-1:0]     r_cval,     n_cval;

    logic                  in_fire;
    logic                  adv;
    logic                  process;
    logic                  clk_access;
    logic [DATA_W-1:0]     rtc_rd;
    t_rtc_ctrl             rtc_ctrl;

    assign adv         = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || adv;
    assign in_fire     = i_in.valid && i_in.ready;
    assign process     = r_in_valid && adv;
    assign i_cfg.ready = 1'b1;

    assign clk_access = (r_ctype == CT_MBC3) && r_clk_en &&
                        (r_clk_sel inside {[4'h8:4'hC]});

    always_comb begin
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        n_mode       = r_mode;
        n_rom_lo     = r_rom_lo;
        n_rom_hi     = r_rom_hi;
        n_clk_en     = r_clk_en;
        n_clk_sel    = r_clk_sel;
        n_latch_prev = r_latch_prev;
        n_target     = TGT_NONE;
        n_is_write   = 1'b0;
        n_maddr      = '0;
        n_cval       = '0;
        rtc_ctrl     = '{tick: 1'b0, wr: 1'b0, latch: 1'b0,
                         idx: r_clk_sel[CLK_IDX_W-1:0], data: r_data};

        if (r_op == OP_TICK) begin
            rtc_ctrl.tick = process;
        end else if (r_op == OP_READ || r_op == OP_WRITE) begin
            if (r_op == OP_WRITE && !r_addr[15]) begin
                case (r_ctype)
                    CT_MBC1: begin
                        case (r_addr[15:13])
                            RGN_ROM_SEL: n_rom_bank = mbc1_fix(
                                (r_rom_bank & 9'h0E0) | {4'b0, r_data[4:0]});
                            RGN_UPPER: begin
                                if (!r_mode) begin
                                    n_rom_bank = mbc1_fix(
                                        (r_rom_bank & 9'h01F) | {2'b0, r_data[1:0], 5'b0});
                                end else begin
                                    n_ram_bank = {2'b0, r_data[1:0]};
                                end
                            end
                            RGN_MODE: n_mode = r_data[0];
                            default: ;
                        endcase
                    end
                    CT_MBC2: begin
                        if (r_addr[15:13] == RGN_ROM_SEL) begin
                            n_rom_bank = (r_data[3:0] == 4'd0) ? 9'd1 : {5'b0, r_data[3:0]};
                        end
                    end
                    CT_MBC3: begin
                        case (r_addr[15:13])
                            RGN_ROM_SEL: n_rom_bank =
                                (r_data[6:0] == 7'd0) ? 9'd1 : {2'b0, r_data[6:0]};
                            RGN_UPPER: begin
                                if (r_data inside {[8'h00:8'h03]}) begin
                                    n_ram_bank = r_data[RAM_BANK_W-1:0];
                                    n_clk_en   = 1'b0;
                                end else if (r_data inside {[8'h08:8'h0C]}) begin
                                    n_clk_sel = r_data[CLK_SEL_W-1:0];
                                    n_clk_en  = 1'b1;
                                end
                            end
                            RGN_MODE: begin
                                // latch on a rising edge of data bit 0
                                rtc_ctrl.latch = process && !r_latch_prev && r_data[0];
                                n_latch_prev   = r_data[0];
                            end
                            default: ;
                        endcase
                    end
                    CT_MBC5: begin
                        if (r_addr[15:12] == RGN5_ROM_LO) begin
                            n_rom_lo   = r_data;
                            n_rom_bank = {r_rom_hi, r_data};
                        end else if (r_addr[15:12] == RGN5_ROM_HI) begin
                            n_rom_hi   = r_data[0];
                            n_rom_bank = {r_data[0], r_rom_lo};
                        end else if (r_addr[15:13] == RGN_UPPER) begin
                            n_ram_bank = r_data[RAM_BANK_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end else if (r_addr[15:14] == 2'b00) begin
                n_target = TGT_ROM;
                n_maddr  = {7'b0, r_addr};
            end else if (!r_addr[15]) begin
                n_target = TGT_ROM;
                n_maddr  = {r_rom_bank & BANK_MASK, r_addr[13:0]};
            end else if (r_addr[15:13] == RGN_EXT_RAM) begin
                n_is_write = r_op[0];
                if (clk_access) begin
                    n_target    = TGT_CLOCK;
                    rtc_ctrl.wr = process && r_op[0];
                    n_cval      = r_op[0] ? r_data : rtc_rd;
                end else begin
                    n_target = TGT_RAM;
                    n_maddr  = {6'b0, r_ram_bank, r_addr[12:0]};
                end
            end
        end
    end

    cbc_rtc u_rtc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (rtc_ctrl),
        .o_rd_data (rtc_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ctype      <= CT_NONE;
            r_rom_bank   <= 9'd1;
            r_ram_bank   <= '0;
            r_mode       <= 1'b0;
            r_rom_lo     <= '0;
            r_rom_hi     <= 1'b0;
            r_clk_en     <= 1'b0;
            r_clk_sel    <= '0;
            r_latch_prev <= 1'b0;
        end else begin
            r_in_valid <= in_fire || (r_in_valid && !adv);
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg.valid) begin
                r_ctype <= i_cfg.data;
            end
            if (process) begin
                r_rom_bank   <= n_rom_bank;
                r_ram_bank   <= n_ram_bank;
                r_mode       <= n_mode;
                r_rom_lo     <= n_rom_lo;
                r_rom_hi     <= n_rom_hi;
                r_clk_en     <= n_clk_en;
                r_clk_sel    <= n_clk_sel;
                r_latch_prev <= n_latch_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_in.op;
            r_addr <= i_in.address;
            r_data <= i_in.data;
        end
        if (adv) begin
            r_target   <= n_target;
            r_is_write <= n_is_write;
            r_maddr    <= n_maddr;
            r_cval     <= n_cval;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.target      = r_target;
    assign o_out.is_write    = r_is_write;
    assign o_out.mem_address = r_maddr;
    assign o_out.clock_value = r_cval;

endmodule

FILE: hdl/cbc_checker.sv
// port-level assertions for the bank controller, bound to the top level
module cbc_checker import cbc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic [TGT_W-1:0]   i_target,
    input logic               i_is_write,
    input logic [MADDR_W-1:0] i_mem_address,
    input logic [DATA_W-1:0]  i_clock_value
);

    // no result comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_none_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_target == TGT_NONE) |->
            (!i_is_write && i_mem_address == '0 && i_clock_value == '0))
        else $error("target none with nonzero fields");

    // rom writes are commands, never mapped accesses
    a_rom_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_target == TGT_ROM) |-> (!i_is_write && i_clock_value == '0))
        else $error("rom access flagged as write or with clock value");

    a_clock_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_target == TGT_CLOCK) |-> (i_mem_address == '0))
        else $error("clock access with memory address");

    a_ram_no_cval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_target == TGT_RAM) |-> (i_clock_value == '0))
        else $error("ram access with clock value");

endmodule

bind cartridge_bank_controller_rtc_top cbc_checker u_cbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_target      (o_out.target),
    .i_is_write    (o_out.is_write),
    .i_mem_address (o_out.mem_address),
    .i_clock_value (o_out.clock_value)
);

FILE: tb/cartridge_bank_controller_rtc_top_test.sv
// self-checking testbench for the cartridge bank controller with real-time clock
`timescale 1ns / 100ps

module cartridge_bank_controller_rtc_top_test;
    import cbc_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 4000;
    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 95;

    localparam t_op    OP_UNUSED      = 2'd3;
    localparam t_ctype CT_UNKNOWN_LO  = 3'd5;
    localparam t_ctype CT_UNKNOWN_HI  = 3'd7;
    localparam logic [3:0] RTC_SEL_FIRST = 4'h8;
    localparam logic [3:0] RTC_SEL_LAST  = 4'hC;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_MASK =
        ROM_BANK_W'((1 << ROM_BANK_BITS_DEF) - 1);

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_bus_item;

    typedef struct packed {
        t_target            target;
        logic               is_write;
        logic [MADDR_W-1:0] mem_address;
        logic [DATA_W-1:0]  clock_value;
    } t_mapped_access;

    logic i_clk;
    logic i_rst_n;

    cbc_in_if  access_ch ();
    cbc_out_if mapped_ch ();
    cbc_cfg_if ctype_ch ();

    cartridge_bank_controller_rtc_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (access_ch),
        .o_out   (mapped_ch),
        .i_cfg   (ctype_ch)
    );

    // predicted controller state
    t_ctype                ctype;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  bank_mode;
    logic [7:0]            bank_low;
    logic                  bank_hi;
    logic                  rtc_selected;
    logic [3:0]            rtc_reg_sel;
    logic                  latch_prev;
    logic [DATA_W-1:0]     rtc_live [CLK_REGS];
    logic [DATA_W-1:0]     rtc_held [CLK_REGS];

    t_bus_item      access_backlog [$];
    t_mapped_access awaited_maps [$];
    int unsigned    queued_total;
    int unsigned    accepted_total;
    int unsigned    failures;
    int unsigned    send_gap_pct;
    int unsigned    sink_stall_pct;
    logic           in_taken;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---------------- predictor ----------------

    // mbc1 cannot address banks 0x00/0x20/0x40/0x60
    function automatic logic [ROM_BANK_W-1:0] skip_dead_bank(logic [ROM_BANK_W-1:0] b);
        if (b[4:0] == 5'd0 && b[8:7] == 2'b00) begin
            return b + 9'd1;
        end
        return b;
    endfunction

    function automatic void apply_bank_command(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        case (ctype)
            CT_MBC1: begin
                if (a >= 16'h2000 && a < 16'h4000) begin
                    rom_bank = skip_dead_bank((rom_bank & 9'h0E0) | {4'b0, d[4:0]});
                end else if (a >= 16'h4000 && a < 16'h6000) begin
                    if (!bank_mode) begin
                        rom_bank = skip_dead_bank((rom_bank & 9'h01F) | {2'b0, d[1:0], 5'b0});
                    end else begin
                        ram_bank = {2'b0, d[1:0]};
                    end
                end else if (a >= 16'h6000) begin
                    bank_mode = d[0];
                end
            end
            CT_MBC2: begin
                if (a >= 16'h2000 && a < 16'h4000) begin
                    rom_bank = (d[3:0] == 4'd0) ? 9'd1 : {5'b0, d[3:0]};
                end
            end
            CT_MBC3: begin
                if (a >= 16'h2000 && a < 16'h4000) begin
                    rom_bank = (d[6:0] == 7'd0) ? 9'd1 : {2'b0, d[6:0]};
                end else if (a >= 16'h4000 && a < 16'h6000) begin
                    if (d <= 8'd3) begin
                        ram_bank     = d[3:0];
                        rtc_selected = 1'b0;
                    end else if (d >= 8'(RTC_SEL_FIRST) && d <= 8'(RTC_SEL_LAST)) begin
                        rtc_reg_sel  = d[3:0];
                        rtc_selected = 1'b1;
                    end
                end else if (a >= 16'h6000) begin
                    // latch only on a rising bit 0
                    if (!latch_prev && d[0]) begin
                        rtc_held = rtc_live;
                    end
                    latch_prev = d[0];
                end
            end
            CT_MBC5: begin
                if (a >= 16'h2000 && a < 16'h3000) begin
                    bank_low = d;
                    rom_bank = {bank_hi, bank_low};
                end else if (a >= 16'h3000 && a < 16'h4000) begin
                    bank_hi  = d[0];
                    rom_bank = {bank_hi, bank_low};
                end else if (a >= 16'h4000 && a < 16'h6000) begin
                    ram_bank = d[3:0];
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void advance_rtc();
        logic [9:0] day;
        if (rtc_live[CLK_DAY_HI][HALT_BIT]) return;
        rtc_live[CLK_SEC] = rtc_live[CLK_SEC] + 8'd1;
        if (rtc_live[CLK_SEC] < SEC_LIMIT) return;
        rtc_live[CLK_SEC] = 8'd0;
        rtc_live[CLK_MIN] = rtc_live[CLK_MIN] + 8'd1;
        if (rtc_live[CLK_MIN] < SEC_LIMIT) return;
        rtc_live[CLK_MIN]  = 8'd0;
        rtc_live[CLK_HOUR] = rtc_live[CLK_HOUR] + 8'd1;
        if (rtc_live[CLK_HOUR] < HOUR_LIMIT) return;
        rtc_live[CLK_HOUR] = 8'd0;
        day = {1'b0, rtc_live[CLK_DAY_HI][DAY_MSB_BIT], rtc_live[CLK_DAY_LO]} + 10'd1;
        // 9-bit day counter wraps, then flags the carry
        if (day[9]) begin
            day = '0;
            rtc_live[CLK_DAY_HI][CARRY_BIT] = 1'b1;
        end
        rtc_live[CLK_DAY_LO] = day[7:0];
        rtc_live[CLK_DAY_HI][DAY_MSB_BIT] = day[8];
    endfunction

    function automatic t_mapped_access map_bus_access(t_op op, logic [ADDR_W-1:0] a,
                                                      logic [DATA_W-1:0] d);
        t_mapped_access        r;
        logic [ROM_BANK_W-1:0] bank;
        int unsigned           slot;
        r = '0;
        if (op == OP_TICK) begin
            advance_rtc();
        end else if (op == OP_READ || op == OP_WRITE) begin
            if (op == OP_WRITE && a < 16'h8000) begin
                apply_bank_command(a, d);
            end else if (a < 16'h4000) begin
                r.target      = TGT_ROM;
                r.mem_address = MADDR_W'(a);
            end else if (a < 16'h8000) begin
                bank          = rom_bank & ROM_BANK_MASK;
                r.target      = TGT_ROM;
                r.mem_address = {bank, a[13:0]};
            end else if (a >= 16'hA000 && a < 16'hC000) begin
                r.is_write = (op == OP_WRITE);
                if (ctype == CT_MBC3 && rtc_selected &&
                    rtc_reg_sel >= RTC_SEL_FIRST && rtc_reg_sel <= RTC_SEL_LAST) begin
                    slot     = rtc_reg_sel - RTC_SEL_FIRST;
                    r.target = TGT_CLOCK;
                    if (op == OP_WRITE) begin
                        rtc_live[slot] = d;
                        rtc_held[slot] = d;
                    end
                    r.clock_value = rtc_held[slot];
                end else begin
                    r.target      = TGT_RAM;
                    r.mem_address = MADDR_W'({ram_bank, a[12:0]});
                end
            end
        end
        return r;
    endfunction

    // ---------------- driver and monitor ----------------

    always @(negedge i_clk) begin : driver
        t_bus_item nxt;
        if (!i_rst_n) begin
            access_ch.valid <= 1'b0;
        end else if (!access_ch.valid || in_taken) begin
            if (access_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = access_backlog.pop_front();
                access_ch.valid   <= 1'b1;
                access_ch.op      <= nxt.op;
                access_ch.address <= nxt.address;
                access_ch.data    <= nxt.data;
            end else begin
                access_ch.valid <= 1'b0;
            end
        end
        mapped_ch.ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_mapped_access seen;
        t_mapped_access want;
        t_mapped_access pred;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= access_ch.valid && access_ch.ready;
            if (mapped_ch.valid && mapped_ch.ready) begin
                seen.target      = mapped_ch.target;
                seen.is_write    = mapped_ch.is_write;
                seen.mem_address = mapped_ch.mem_address;
                seen.clock_value = mapped_ch.clock_value;
                if (awaited_maps.size() == 0) begin
                    $error("mapped access with none outstanding: target %0d address 0x%0h",
                           seen.target, seen.mem_address);
                    failures++;
                end else begin
                    want = awaited_maps.pop_front();
                    check_field("target", 32'(want.target), 32'(seen.target));
                    check_field("is_write", 32'(want.is_write), 32'(seen.is_write));
                    check_field("mem_address", 32'(want.mem_address),
                                32'(seen.mem_address));
                    check_field("clock_value", 32'(want.clock_value),
                                32'(seen.clock_value));
                end
            end
            if (access_ch.valid && access_ch.ready) begin
                pred = map_bus_access(access_ch.op, access_ch.address, access_ch.data);
                awaited_maps = {awaited_maps, pred};
                accepted_total++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (access_ch.valid && access_ch.ready) ||
                (mapped_ch.valid && mapped_ch.ready) || (ctype_ch.valid && ctype_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // ---------------- stimulus ----------------

    task automatic enqueue(input t_op op, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
        t_bus_item it;
        it.op      = op;
        it.address = a;
        it.data    = d;
        access_backlog = {access_backlog, it};
        queued_total++;
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || awaited_maps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_controller_type(input t_ctype v);
        @(negedge i_clk);
        ctype_ch.valid <= 1'b1;
        ctype_ch.data  <= v;
        do @(posedge i_clk); while (!(ctype_ch.valid && ctype_ch.ready));
        ctype = v;
        @(negedge i_clk);
        ctype_ch.valid <= 1'b0;
    endtask

    function automatic t_ctype phase_controller(int ph);
        case (ph)
            0, 4, 8: return CT_MBC3;
            1, 7:    return CT_MBC1;
            2, 10:   return CT_MBC5;
            3:       return CT_MBC2;
            5:       return CT_UNKNOWN_HI;
            6:       return CT_NONE;
            default: return CT_UNKNOWN_LO;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rtc_select_code(int idx);
        return 8'(RTC_SEL_FIRST) + 8'(idx);
    endfunction

    function automatic logic [ADDR_W-1:0] ram_window_addr();
        return 16'($urandom_range(16'hBFFF, 16'hA000));
    endfunction

    function automatic logic [DATA_W-1:0] rtc_pick_value(int idx, bit at_limit);
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] v;
        if (idx == CLK_DAY_HI) begin
            v = 8'($urandom_range(255));
            if (at_limit || $urandom_range(3) != 0) v[HALT_BIT] = 1'b0;
            if (at_limit) v[DAY_MSB_BIT] = ($urandom_range(3) != 0);
            return v;
        end
        case (idx)
            CLK_SEC, CLK_MIN: top = SEC_LIMIT - 8'd1;
            CLK_HOUR:         top = HOUR_LIMIT - 8'd1;
            default:          top = 8'hFF;
        endcase
        if (at_limit || $urandom_range(1)) return top;
        if ($urandom_range(3) != 0) return 8'($urandom_range(top));
        // out-of-range values go to zero and carry on the next tick; 0xFF wraps to zero without a carry
        return $urandom_range(1) ? 8'hFF : 8'($urandom_range(255));
    endfunction

    // set some clock registers, tick, latch, then read back the latched copy
    task automatic queue_clock_scene();
        bit          rollover;
        int unsigned reads;
        int unsigned slot;
        rollover = ($urandom_range(9) < 3);
        for (int i = 0; i < CLK_REGS; i++) begin
            if (rollover || $urandom_range(9) < 7) begin
                enqueue(OP_WRITE, 16'($urandom_range(16'h5FFF, 16'h4000)), rtc_select_code(i));
                enqueue(OP_WRITE, ram_window_addr(), rtc_pick_value(i, rollover));
            end
        end
        repeat ($urandom_range(4, 1)) begin
            enqueue(OP_TICK, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
        end
        enqueue(OP_WRITE, 16'($urandom_range(16'h7FFF, 16'h6000)), {7'($urandom_range(127)), 1'b0});
        enqueue(OP_WRITE, 16'($urandom_range(16'h7FFF, 16'h6000)), {7'($urandom_range(127)), 1'b1});
        reads = rollover ? CLK_REGS : $urandom_range(3, 1);
        for (int i = 0; i < reads; i++) begin
            slot = rollover ? i : $urandom_range(CLK_REGS - 1);
            enqueue(OP_WRITE, 16'($urandom_range(16'h5FFF, 16'h4000)), rtc_select_code(slot));
            enqueue(OP_READ, ram_window_addr(), 8'($urandom_range(255)));
        end
        if ($urandom_range(1)) begin
            enqueue(OP_WRITE, 16'($urandom_range(16'h5FFF, 16'h4000)), 8'($urandom_range(3)));
        end
    endtask

    task automatic queue_random_access();
        int unsigned       pick;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        pick = $urandom_range(99);
        if (pick < 25) begin
            case ($urandom_range(4))
                0:       a = 16'($urandom_range(16'h1FFF));
                1:       a = 16'($urandom_range(16'h2FFF, 16'h2000));
                2:       a = 16'($urandom_range(16'h3FFF, 16'h3000));
                3:       a = 16'($urandom_range(16'h5FFF, 16'h4000));
                default: a = 16'($urandom_range(16'h7FFF, 16'h6000));
            endcase
            case ($urandom_range(3))
                0:       d = 8'($urandom_range(255));
                1:       d = 8'($urandom_range(15));
                2:       d = {1'b0, 2'($urandom_range(3)), 5'd0};
                default: d = 8'($urandom_range(1));
            endcase
            enqueue(OP_WRITE, a, d);
        end else if (pick < 50) begin
            enqueue($urandom_range(1) ? OP_WRITE : OP_READ, ram_window_addr(),
                    8'($urandom_range(255)));
        end else if (pick < 68) begin
            enqueue(OP_READ, 16'($urandom_range(16'h7FFF)), 8'($urandom_range(255)));
        end else if (pick < 80) begin
            enqueue(OP_TICK, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
        end else begin
            enqueue(t_op'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                    8'($urandom_range(255)));
        end
    endtask

    task automatic queue_directed();
        // fixed area, banked area edges, bank zero forced to one
        enqueue(OP_READ, 16'h0000, 8'h00);
        enqueue(OP_READ, 16'h3FFF, 8'hFF);
        enqueue(OP_READ, 16'h4000, 8'h00);
        enqueue(OP_WRITE, 16'h2000, 8'h00);
        enqueue(OP_READ, 16'h7FFF, 8'h00);
        enqueue(OP_WRITE, 16'h3FFF, 8'hFF);
        enqueue(OP_READ, 16'h7FFF, 8'h00);
        // ram bank and window edges, unmapped areas
        enqueue(OP_WRITE, 16'h4000, 8'h03);
        enqueue(OP_READ, 16'hA000, 8'h00);
        enqueue(OP_WRITE, 16'hBFFF, 8'hFF);
        enqueue(OP_READ, 16'h8000, 8'h00);
        enqueue(OP_WRITE, 16'hC000, 8'h55);
        enqueue(OP_READ, 16'hFFFF, 8'h00);
        // seconds written, ticked, latched
        enqueue(OP_WRITE, 16'h5FFF, rtc_select_code(CLK_SEC));
        enqueue(OP_WRITE, 16'hA000, SEC_LIMIT - 8'd1);
        enqueue(OP_TICK, 16'h0000, 8'h00);
        enqueue(OP_READ, 16'hA000, 8'h00);
        enqueue(OP_WRITE, 16'h6000, 8'h00);
        enqueue(OP_WRITE, 16'h7FFF, 8'h01);
        enqueue(OP_READ, 16'hBFFF, 8'h00);
        // halted clock ignores ticks; unused op and ignored select value
        enqueue(OP_WRITE, 16'h4000, rtc_select_code(CLK_DAY_HI));
        enqueue(OP_WRITE, 16'hA000, 8'(1 << HALT_BIT));
        enqueue(OP_TICK, 16'hFFFF, 8'hFF);
        enqueue(OP_UNUSED, 16'hA000, 8'hAA);
        enqueue(OP_WRITE, 16'h4000, 8'h05);
    endtask

    initial begin : stimulus
        int unsigned fill_goal;
        i_rst_n             = 1'b0;
        access_ch.valid     = 1'b0;
        access_ch.op        = OP_READ;
        access_ch.address   = '0;
        access_ch.data      = '0;
        mapped_ch.ready     = 1'b0;
        ctype_ch.valid      = 1'b0;
        ctype_ch.data       = CT_NONE;
        in_taken            = 1'b0;
        queued_total        = 0;
        accepted_total      = 0;
        failures            = 0;
        send_gap_pct        = 32;
        sink_stall_pct      = 56;
        ctype               = CT_NONE;
        rom_bank            = 9'd1;
        ram_bank            = '0;
        bank_mode           = 1'b0;
        bank_low            = '0;
        bank_hi             = 1'b0;
        rtc_selected        = 1'b0;
        rtc_reg_sel         = '0;
        latch_prev          = 1'b0;
        for (int i = 0; i < CLK_REGS; i++) begin
            rtc_live[i] = '0;
            rtc_held[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph < 4) begin
                send_gap_pct   = 32;
                sink_stall_pct = 56;
            end else if (ph < 8) begin
                send_gap_pct   = 56;
                sink_stall_pct = 32;
            end else begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            write_controller_type(phase_controller(ph));
            if (ph == 0) queue_directed();
            fill_goal = queued_total + ITEMS_PER_PHASE;
            while (queued_total < fill_goal) begin
                if (ctype == CT_MBC3 && $urandom_range(2) == 0) begin
                    queue_clock_scene();
                end else begin
                    queue_random_access();
                end
            end
        end
        wait_drained();

        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
